// File: hw/rtl/tkps_pkg.sv
`default_nettype none

package tkps_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;

  // Band table: ten 12-bit sizes in MB, split over two registers.
  localparam int BAND_W     = 12;
  localparam int BAND_TOTAL = 10;
  localparam int BAND_IDX_W = 4;
  localparam int TABLE_W    = BAND_W * BAND_TOTAL;

  // Datapath widths, sized to the largest value each one can carry.
  localparam int DIV_W     = 42;
  localparam int DIV_CNT_W = 6;
  localparam int PTS_W     = 40;
  localparam int PAGES_W   = 37;
  localparam int SIZE_W    = 29;
  localparam int PAGE_SHIFT = 8;

  // Fixed factors of the scoring rules.
  localparam int PCT       = 100;
  localparam int ADMIN_PCT = 3;

  // Register reset values.
  localparam logic [15:0]         RST_CACHE_GAP  = 16'd200;
  localparam logic [9:0]          RST_CACHED_MIN = 10'd900;
  localparam logic [9:0]          RST_SWAP_RATIO = 10'd100;
  localparam logic [CFG_DATA_W-1:0] RST_BAND_LOW  = 60'd84463113890613200;
  localparam logic [CFG_DATA_W-1:0] RST_BAND_HIGH = 60'd45046994075156680;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CACHE_GAP  = 3'd0,
    REG_CACHED_MIN = 3'd1,
    REG_SWAP_RATIO = 3'd2,
    REG_BAND_LOW   = 3'd3,
    REG_BAND_HIGH  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0]           cache_gap;
    logic [9:0]            cached_min_level;
    logic [9:0]            swap_ratio_pct;
    logic [CFG_DATA_W-1:0] band_table_high;
    logic [CFG_DATA_W-1:0] band_table_low;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [BAND_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quot;
    logic [BAND_W-1:0] rem;
  } div_rsp_t;

  // Band size at a table index; a zero entry counts as one MB.
  function automatic logic [BAND_W-1:0] band_pick(input logic [TABLE_W-1:0] tbl,
                                                  input logic [BAND_IDX_W-1:0] idx);
    logic [BAND_W-1:0] v;
    v = '0;
    for (int e = 0; e < BAND_TOTAL; e++) begin
      if (idx == BAND_IDX_W'(e)) begin
        v = tbl[e*BAND_W +: BAND_W];
      end
    end
    if (v == '0) begin
      v = BAND_W'(1);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tkps_cfg.sv
`default_nettype none

module tkps_cfg
  import tkps_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  // Register file; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cache_gap        <= RST_CACHE_GAP;
      cfg.cached_min_level <= RST_CACHED_MIN;
      cfg.swap_ratio_pct   <= RST_SWAP_RATIO;
      cfg.band_table_low   <= RST_BAND_LOW;
      cfg.band_table_high  <= RST_BAND_HIGH;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CACHE_GAP:  cfg.cache_gap        <= wr_data[15:0];
        REG_CACHED_MIN: cfg.cached_min_level <= wr_data[9:0];
        REG_SWAP_RATIO: cfg.swap_ratio_pct   <= wr_data[9:0];
        REG_BAND_LOW:   cfg.band_table_low   <= wr_data;
        REG_BAND_HIGH:  cfg.band_table_high  <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tkps_div.sv
`default_nettype none

module tkps_div
  import tkps_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [DIV_W-1:0]     work;
  logic [BAND_W-1:0]    rem;
  logic [BAND_W-1:0]    divisor;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 done;

  logic [BAND_W:0] shifted;
  logic [BAND_W:0] diff;
  logic            fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem, work[DIV_W-1]};
    diff    = shifted - {1'b0, divisor};
    fits    = shifted >= {1'b0, divisor};
  end

  // The dividend register shifts out its bits while quotient bits shift in.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        work    <= req.dividend;
        rem     <= '0;
        divisor <= req.divisor;
        cnt     <= DIV_CNT_W'(DIV_W);
      end else if (cnt != '0) begin
        work <= {work[DIV_W-2:0], fits};
        rem  <= fits ? diff[BAND_W-1:0] : shifted[BAND_W-1:0];
        cnt  <= cnt - DIV_CNT_W'(1);
        done <= (cnt == DIV_CNT_W'(1));
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = work;
  assign rsp.rem  = rem;

endmodule

`default_nettype wire

// File: hw/rtl/task_kill_priority_score.sv
`default_nettype none

// Channel   Dir  Handshake               Payload
// s_*       in   s_tvalid / s_tready     s_tdata: task sizes and adj, s_tuser: flags
// m_*       out  m_tvalid / m_tready     m_tdata: kill_score
// cfg_*     in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A task with a non-positive adjustment or the skip flag goes straight to ST_OUT.
// Other tasks run the swap scaling, the band walk, then the band share or the two
// tail divisions, and for admin tasks the admin cut; each division runs on the one
// radix-2 divider, and the band walk steps one band per cycle.
// Reset is synchronous; the configuration registers return to their defaults.
// A stalled m_tready holds the result word and delays only the next task's finish.
module task_kill_priority_score
  import tkps_pkg::*;
#(
  parameter int BAND_COUNT = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // [10:0] score_adj, [42:11] resident_pages, [74:43] swapped_pages,
  // [106:75] table_pages, [111:107] zero
  input  wire logic [111:0]          s_tdata,
  // [0] skip_task, [1] is_admin
  input  wire logic [1:0]            s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // [31:0] kill_score
  output logic [31:0]                m_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [BAND_IDX_W-1:0] BAND_LIMIT = BAND_IDX_W'(BAND_COUNT);
  localparam logic [BAND_IDX_W-1:0] BAND_LAST  = BAND_IDX_W'(BAND_COUNT - 1);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_BASE  = 10'b0000000010,
    ST_SWAP  = 10'b0000000100,
    ST_WALK  = 10'b0000001000,
    ST_PART  = 10'b0000010000,
    ST_REM1  = 10'b0000100000,
    ST_REM2  = 10'b0001000000,
    ST_ADMIN = 10'b0010000000,
    ST_ADMW  = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_t;

  state_t state;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Task registers.
  logic [9:0]            adj;
  logic                  admin;
  logic                  zero_score;
  logic [31:0]           rss;
  logic [31:0]           swp;
  logic [31:0]           tbl;
  logic [PTS_W-1:0]      points;
  logic [SIZE_W-1:0]     size;
  logic [BAND_IDX_W-1:0] idx;
  logic [BAND_W-1:0]     bsel;

  logic                  s_fire;
  logic [10:0]           gap_steps;
  logic [26:0]           gap_prod;
  logic [PTS_W-1:0]      base_points;
  logic [DIV_W-1:0]      swp_prod;
  logic [PAGES_W-1:0]    pages;
  logic [BAND_IDX_W-1:0] idx_start;
  logic [BAND_W-1:0]     band_b;
  logic                  band_full;
  logic [SIZE_W-1:0]     size_left;
  logic [PTS_W-1:0]      tail_whole;
  logic [31:0]           score;

  tkps_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tkps_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign s_fire    = s_tvalid && s_tready;

  // Base points: the adjustment plus the cached-application gap.
  always_comb begin
    gap_steps   = 11'(adj) - 11'(cfg.cached_min_level) + 11'd1;
    gap_prod    = 27'(cfg.cache_gap) * 27'(gap_steps);
    base_points = PTS_W'(adj);
    if (adj >= cfg.cached_min_level) begin
      base_points = PTS_W'(adj) + PTS_W'(gap_prod);
    end
  end

  assign swp_prod = DIV_W'(swp) * DIV_W'(cfg.swap_ratio_pct);
  assign pages    = PAGES_W'(rss) + PAGES_W'(div_rsp.quot[35:0]) + PAGES_W'(tbl);

  // First band index: the adjustment in hundreds.
  always_comb begin
    idx_start = '0;
    for (int k = 1; k <= BAND_TOTAL; k++) begin
      idx_start = idx_start + {3'b000, (adj >= 10'(k * PCT))};
    end
  end

  // Current band and what a full pass through it leaves.
  always_comb begin
    band_b     = band_pick({cfg.band_table_high, cfg.band_table_low}, idx);
    band_full  = size >= SIZE_W'(band_b);
    size_left  = size - SIZE_W'(band_b);
    tail_whole = PTS_W'(div_rsp.quot[SIZE_W-1:0]) * PTS_W'(PCT);
  end

  // Divider requests issued by the sequencer.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = BAND_W'(PCT);
    unique case (state)
      ST_BASE: begin
        div_req.start    = 1'b1;
        div_req.dividend = swp_prod;
      end
      ST_WALK: begin
        div_req.divisor = band_b;
        if (idx < BAND_LIMIT) begin
          if (!band_full) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(size) * DIV_W'(PCT);
          end else if (size_left != '0 && idx == BAND_LAST) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(size_left);
          end
        end
      end
      ST_REM1: begin
        div_req.divisor  = bsel;
        div_req.start    = div_rsp.done;
        div_req.dividend = DIV_W'(div_rsp.rem) * DIV_W'(PCT);
      end
      ST_ADMIN: begin
        div_req.start    = admin;
        div_req.dividend = DIV_W'(points) * DIV_W'(ADMIN_PCT);
      end
      default: ;
    endcase
  end

  // Final score: zero for skipped tasks, else floor of one, saturated to 32 bits.
  always_comb begin
    if (zero_score) begin
      score = '0;
    end else if (points == '0) begin
      score = 32'd1;
    end else if (points[PTS_W-1:32] != '0) begin
      score = '1;
    end else begin
      score = points[31:0];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // The result word is loaded from ST_OUT and leaves on m_tready.
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            adj        <= s_tdata[9:0];
            rss        <= s_tdata[42:11];
            swp        <= s_tdata[74:43];
            tbl        <= s_tdata[106:75];
            admin      <= s_tuser[1];
            zero_score <= s_tdata[10] || (s_tdata[10:0] == '0) || s_tuser[0];
            if (s_tdata[10] || (s_tdata[10:0] == '0) || s_tuser[0]) begin
              state <= ST_OUT;
            end else begin
              state <= ST_BASE;
            end
          end
        end
        ST_BASE: begin
          points <= base_points;
          state  <= ST_SWAP;
        end
        ST_SWAP: begin
          if (div_rsp.done) begin
            size  <= pages[PAGES_W-1:PAGE_SHIFT];
            idx   <= idx_start;
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          bsel <= band_b;
          if (idx >= BAND_LIMIT) begin
            state <= ST_ADMIN;
          end else if (!band_full) begin
            state <= ST_PART;
          end else begin
            points <= points + PTS_W'(PCT);
            size   <= size_left;
            idx    <= idx + BAND_IDX_W'(1);
            if (size_left != '0 && idx == BAND_LAST) begin
              state <= ST_REM1;
            end
          end
        end
        ST_PART: begin
          if (div_rsp.done) begin
            points <= points + PTS_W'(div_rsp.quot[SIZE_W+6:0]);
            state  <= ST_ADMIN;
          end
        end
        ST_REM1: begin
          if (div_rsp.done) begin
            points <= points + tail_whole;
            state  <= ST_REM2;
          end
        end
        ST_REM2: begin
          if (div_rsp.done) begin
            points <= points + PTS_W'(div_rsp.quot[BAND_W-1:0]);
            state  <= ST_ADMIN;
          end
        end
        ST_ADMIN: begin
          state <= admin ? ST_ADMW : ST_OUT;
        end
        ST_ADMW: begin
          if (div_rsp.done) begin
            points <= points - div_rsp.quot[PTS_W-1:0];
            state  <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= score;
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
